>>> design/inv3_pkg.sv
// ----------------------------------------------------------------------------
// inv3_pkg
// Shared types and constants for the 3x3 fixed-point matrix inverse.
// ----------------------------------------------------------------------------
package inv3_pkg;

    localparam int ENTRY_WIDTH       = 32;
    localparam int FRACTION_BITS_DEF = 16;

    // Exact widths of the intermediate integers.
    localparam int PROD_W = 2 * ENTRY_WIDTH;
    localparam int COF_W  = 2 * ENTRY_WIDTH + 1;
    localparam int DET_W  = 3 * ENTRY_WIDTH + 1;

    // Cofactor/determinant front end depth in cycles.
    localparam int COF_LAT = 5;

    // Operand pairs of the eighteen 2x2 minor products, row-major entry index.
    // Cofactor j is product 2j minus product 2j+1.
    localparam logic [3:0] MUL_A [18] = '{
        4'd4, 4'd5, 4'd2, 4'd1, 4'd1, 4'd2, 4'd5, 4'd3, 4'd0,
        4'd2, 4'd2, 4'd0, 4'd3, 4'd4, 4'd1, 4'd0, 4'd0, 4'd1
    };
    localparam logic [3:0] MUL_B [18] = '{
        4'd8, 4'd7, 4'd7, 4'd8, 4'd5, 4'd4, 4'd6, 4'd8, 4'd8,
        4'd6, 4'd3, 4'd5, 4'd7, 4'd6, 4'd6, 4'd7, 4'd4, 4'd3
    };

    // Cofactors used by the first-row expansion of the determinant.
    localparam logic [3:0] EXP_IDX [3] = '{4'd0, 4'd3, 4'd6};

    typedef struct packed {
        logic signed [ENTRY_WIDTH-1:0] a11;
        logic signed [ENTRY_WIDTH-1:0] a12;
        logic signed [ENTRY_WIDTH-1:0] a13;
        logic signed [ENTRY_WIDTH-1:0] a21;
        logic signed [ENTRY_WIDTH-1:0] a22;
        logic signed [ENTRY_WIDTH-1:0] a23;
        logic signed [ENTRY_WIDTH-1:0] a31;
        logic signed [ENTRY_WIDTH-1:0] a32;
        logic signed [ENTRY_WIDTH-1:0] a33;
    } in_item_t;

    typedef struct packed {
        logic signed [ENTRY_WIDTH-1:0] inv11;
        logic signed [ENTRY_WIDTH-1:0] inv12;
        logic signed [ENTRY_WIDTH-1:0] inv13;
        logic signed [ENTRY_WIDTH-1:0] inv21;
        logic signed [ENTRY_WIDTH-1:0] inv22;
        logic signed [ENTRY_WIDTH-1:0] inv23;
        logic signed [ENTRY_WIDTH-1:0] inv31;
        logic signed [ENTRY_WIDTH-1:0] inv32;
        logic signed [ENTRY_WIDTH-1:0] inv33;
        logic                          singular;
        logic                          saturated;
    } out_item_t;

endpackage

>>> design/inv3_cof.sv
// ----------------------------------------------------------------------------
// inv3_cof
// Five-stage front end: minor products, adjugate cofactors, split partial
// products of the first-row expansion, and the exact determinant.
// ----------------------------------------------------------------------------
module inv3_cof
    import inv3_pkg::*;
(
    input  logic                          aclk,
    input  logic                          en,
    input  logic signed [ENTRY_WIDTH-1:0] a_in    [9],
    output logic signed [COF_W-1:0]       cof_out [9],
    output logic signed [DET_W-1:0]       det_out
);

    localparam int W = ENTRY_WIDTH;

    logic signed [PROD_W-1:0] prod_next [18];
    logic signed [PROD_W-1:0] prod_reg  [18];
    logic signed [W-1:0]      row1_s1_reg [3];
    logic signed [W-1:0]      row1_s2_reg [3];
    logic signed [COF_W-1:0]  cof_next [9];
    logic signed [COF_W-1:0]  cof_s2_reg [9];
    logic signed [COF_W-1:0]  cof_s3_reg [9];
    logic signed [COF_W-1:0]  cof_s4_reg [9];
    logic signed [COF_W-1:0]  cof_s5_reg [9];
    logic signed [2*W:0]      phi_next [3];
    logic signed [2*W:0]      plo_next [3];
    logic signed [2*W:0]      phi_reg  [3];
    logic signed [2*W:0]      plo_reg  [3];
    logic signed [DET_W-1:0]  term_next [3];
    logic signed [DET_W-1:0]  term_reg  [3];
    logic signed [DET_W-1:0]  det_next;
    logic signed [DET_W-1:0]  det_reg;

    genvar k;
    generate
        for (k = 0; k < 18; k++) begin : g_prod
            assign prod_next[k] = a_in[MUL_A[k]] * a_in[MUL_B[k]];
        end
        for (k = 0; k < 9; k++) begin : g_cof
            assign cof_next[k] = COF_W'(prod_reg[2*k]) - COF_W'(prod_reg[2*k+1]);
        end
        for (k = 0; k < 3; k++) begin : g_part
            logic signed [W:0] chi;
            logic signed [W:0] clo;
            assign chi         = cof_s2_reg[EXP_IDX[k]][COF_W-1:W];
            assign clo         = {1'b0, cof_s2_reg[EXP_IDX[k]][W-1:0]};
            assign phi_next[k] = row1_s2_reg[k] * chi;
            assign plo_next[k] = row1_s2_reg[k] * clo;
            assign term_next[k] = (DET_W'(phi_reg[k]) <<< W) + DET_W'(plo_reg[k]);
        end
    endgenerate

    assign det_next = term_reg[0] + term_reg[1] + term_reg[2];

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg    <= prod_next;
            row1_s1_reg <= a_in[0:2];
            row1_s2_reg <= row1_s1_reg;
            cof_s2_reg  <= cof_next;
            phi_reg     <= phi_next;
            plo_reg     <= plo_next;
            cof_s3_reg  <= cof_s2_reg;
            term_reg    <= term_next;
            cof_s4_reg  <= cof_s3_reg;
            det_reg     <= det_next;
            cof_s5_reg  <= cof_s4_reg;
        end
    end

    assign cof_out = cof_s5_reg;
    assign det_out = det_reg;

endmodule

>>> design/inv3_div.sv
// ----------------------------------------------------------------------------
// inv3_div
// Pipelined rounded divide of one cofactor by the determinant: magnitudes,
// overflow precheck, one restoring quotient bit per stage, then saturation.
// ----------------------------------------------------------------------------
module inv3_div
    import inv3_pkg::*;
#(
    parameter int FRAC_BITS = FRACTION_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          en,
    input  logic signed [COF_W-1:0]       cof_in,
    input  logic signed [DET_W-1:0]       det_in,
    output logic signed [ENTRY_WIDTH-1:0] res,
    output logic                          sat,
    output logic                          zero
);

    localparam int W     = ENTRY_WIDTH;
    localparam int QW    = W + 1;
    localparam int CMAGW = 2 * W;
    localparam int DMAGW = 3 * W;
    localparam int SHW   = CMAGW + 2 * FRAC_BITS + 1;
    localparam int NUMW  = (SHW > DMAGW ? SHW : DMAGW) + 1;
    localparam int DENW  = DMAGW + 1;
    localparam int HIW   = NUMW - QW;
    localparam int CMPW  = (HIW > DENW ? HIW : DENW);

    // magnitudes
    logic [COF_W-1:0] cof_neg;
    logic [DET_W-1:0] det_neg;
    logic [CMAGW-1:0] acof_reg;
    logic [DMAGW-1:0] adet_reg;
    logic             neg1_reg;
    // rounding numerator and doubled divisor
    logic [NUMW-1:0]  num_reg;
    logic [DENW-1:0]  den2_reg;
    logic             neg2_reg;
    logic             zero2_reg;
    // divide stages
    logic [HIW-1:0]   hi;
    logic [DENW-1:0]  rem_reg  [QW+1];
    logic [QW-1:0]    low_reg  [QW+1];
    logic [QW-1:0]    q_reg    [QW+1];
    logic [DENW-1:0]  den_reg  [QW+1];
    logic [QW:0]      neg_reg;
    logic [QW:0]      ovf_reg;
    logic [QW:0]      zero_reg;
    logic [DENW-1:0]  rem_next [QW];
    logic [QW-1:0]    q_next   [QW];
    // saturation
    logic [QW-1:0]    limit;
    logic             sat_next;
    logic [QW-1:0]    mag;
    logic [QW-1:0]    sres;
    logic [W-1:0]     res_reg;
    logic             sat_reg;
    logic             zero_out_reg;

    assign cof_neg = -cof_in;
    assign det_neg = -det_in;
    assign hi      = num_reg[NUMW-1:QW];

    genvar i;
    generate
        for (i = 0; i < QW; i++) begin : g_step
            logic [DENW:0] trial;
            logic [DENW:0] diff;
            logic          ge;
            assign trial       = {rem_reg[i], low_reg[i][QW-1-i]};
            assign ge          = trial >= {1'b0, den_reg[i]};
            assign diff        = trial - {1'b0, den_reg[i]};
            assign rem_next[i] = ge ? diff[DENW-1:0] : trial[DENW-1:0];
            assign q_next[i]   = {q_reg[i][QW-2:0], ge};

            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[i+1]  <= rem_next[i];
                    low_reg[i+1]  <= low_reg[i];
                    q_reg[i+1]    <= q_next[i];
                    den_reg[i+1]  <= den_reg[i];
                    neg_reg[i+1]  <= neg_reg[i];
                    ovf_reg[i+1]  <= ovf_reg[i];
                    zero_reg[i+1] <= zero_reg[i];
                end
            end
        end
    endgenerate

    always_comb begin
        limit    = neg_reg[QW] ? {2'b01, {(W-1){1'b0}}} : {2'b00, {(W-1){1'b1}}};
        sat_next = ovf_reg[QW] || (q_reg[QW] > limit);
        mag      = sat_next ? limit : q_reg[QW];
        sres     = neg_reg[QW] ? -mag : mag;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // take magnitudes and the quotient sign
            acof_reg  <= cof_in[COF_W-1] ? cof_neg[CMAGW-1:0] : cof_in[CMAGW-1:0];
            adet_reg  <= det_in[DET_W-1] ? det_neg[DMAGW-1:0] : det_in[DMAGW-1:0];
            neg1_reg  <= cof_in[COF_W-1] ^ det_in[DET_W-1];
            // 2|n| + |d| over 2|d| rounds to nearest, ties away from zero
            num_reg   <= NUMW'({acof_reg, {(2*FRAC_BITS+1){1'b0}}}) + NUMW'(adet_reg);
            den2_reg  <= {adet_reg, 1'b0};
            neg2_reg  <= neg1_reg;
            zero2_reg <= (adet_reg == '0);
            // quotient needs more than QW bits when the high part reaches den
            rem_reg[0]  <= DENW'(hi);
            low_reg[0]  <= num_reg[QW-1:0];
            q_reg[0]    <= '0;
            den_reg[0]  <= den2_reg;
            neg_reg[0]  <= neg2_reg;
            ovf_reg[0]  <= CMPW'(hi) >= CMPW'(den2_reg);
            zero_reg[0] <= zero2_reg;
            // clip, restore sign, force zero on a singular matrix
            res_reg      <= zero_reg[QW] ? '0 : sres[W-1:0];
            sat_reg      <= sat_next && !zero_reg[QW];
            zero_out_reg <= zero_reg[QW];
        end
    end

    assign res  = res_reg;
    assign sat  = sat_reg;
    assign zero = zero_out_reg;

endmodule

>>> design/matrix3x3_inverse_top.sv
// ----------------------------------------------------------------------------
// matrix3x3_inverse_top
// Inverse of a signed fixed-point 3x3 matrix by adjugate and determinant.
// ----------------------------------------------------------------------------
// Front end of minor products, cofactors and determinant, then a divider
// pipeline with one quotient bit per stage. Throughput: one matrix per cycle
// while the output transfer is not stalled.
// Reset clears only the valid bits of the pipeline; data registers run free.
// ----------------------------------------------------------------------------
module matrix3x3_inverse_top
    import inv3_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    localparam int LAT = COF_LAT + ENTRY_WIDTH + 5;

    logic                          adv;
    logic [LAT-1:0]                vld_reg;
    logic [LAT-1:0]                vld_next;
    logic signed [ENTRY_WIDTH-1:0] a_vec   [9];
    logic signed [COF_W-1:0]       cof_vec [9];
    logic signed [DET_W-1:0]       det;
    logic signed [ENTRY_WIDTH-1:0] inv_vec [9];
    logic [8:0]                    sat_vec;
    logic [8:0]                    zero_vec;

    // The whole pipeline moves together; hold every stage while the output
    // transfer is stalled, advance otherwise so bubbles fill each cycle.
    assign adv     = !vld_reg[LAT-1] || m_ready;
    assign s_ready = adv;
    assign m_valid = vld_reg[LAT-1];

    assign vld_next = {vld_reg[LAT-2:0], s_valid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= vld_next;
        end
    end

    // unpack the matrix row-major
    assign a_vec[0] = s_data.a11;
    assign a_vec[1] = s_data.a12;
    assign a_vec[2] = s_data.a13;
    assign a_vec[3] = s_data.a21;
    assign a_vec[4] = s_data.a22;
    assign a_vec[5] = s_data.a23;
    assign a_vec[6] = s_data.a31;
    assign a_vec[7] = s_data.a32;
    assign a_vec[8] = s_data.a33;

    inv3_cof u_cof (
        .aclk    (aclk),
        .en      (adv),
        .a_in    (a_vec),
        .cof_out (cof_vec),
        .det_out (det)
    );

    // one divider per inverse entry, all sharing the same determinant
    genvar k;
    generate
        for (k = 0; k < 9; k++) begin : g_div
            inv3_div #(
                .FRAC_BITS (FRACTION_BITS)
            ) u_div (
                .aclk   (aclk),
                .en     (adv),
                .cof_in (cof_vec[k]),
                .det_in (det),
                .res    (inv_vec[k]),
                .sat    (sat_vec[k]),
                .zero   (zero_vec[k])
            );
        end
    endgenerate

    // pack the result; every divider sees the same zero determinant flag
    assign m_data.inv11     = inv_vec[0];
    assign m_data.inv12     = inv_vec[1];
    assign m_data.inv13     = inv_vec[2];
    assign m_data.inv21     = inv_vec[3];
    assign m_data.inv22     = inv_vec[4];
    assign m_data.inv23     = inv_vec[5];
    assign m_data.inv31     = inv_vec[6];
    assign m_data.inv32     = inv_vec[7];
    assign m_data.inv33     = inv_vec[8];
    assign m_data.singular  = zero_vec[0];
    assign m_data.saturated = |sat_vec;

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 3x3 fixed-point matrix inverse. A directed
// table covers identity, singular and saturating matrices; random matrices
// of several kinds follow. Results are checked against typed expectations
// or an exact adjugate/determinant model, round-half-away and saturating.
// ----------------------------------------------------------------------------
module tb_top;
    import inv3_pkg::*;

    localparam int  NUM_RANDOM    = 1530;
    localparam int  IDLE_LIMIT    = 4000;
    localparam int  DRAIN_CYCLES  = 3 * (ENTRY_WIDTH + 10);
    localparam int  RX_HOLD_CYCLES = 600;
    localparam logic [ENTRY_WIDTH-1:0] ONE  = 32'h0001_0000;
    localparam logic [ENTRY_WIDTH-1:0] HALF = 32'h0000_8000;
    localparam logic [ENTRY_WIDTH-1:0] MAXP = 32'h7fff_ffff;
    localparam logic [ENTRY_WIDTH-1:0] MAXN = 32'h8000_0000;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    out_item_t pending_inverses[$];
    int        error_count = 0;
    int        results_seen = 0;
    int        idle_cycles = 0;
    bit        calm_phase = 1'b0;   // no idling on either side while set
    bit        override_on = 1'b0;  // typed expectation travels with the transfer
    out_item_t override_want = '0;

    always #2 aclk = ~aclk;

    matrix3x3_inverse_top DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // ------------------------------------------------------------------------
    // Exact inverse: adjugate and determinant as wide integers, then each
    // entry = round(cof * 2^(2F) / det), ties away from zero, saturated; zero det gives singular.
    // ------------------------------------------------------------------------
    function automatic logic [ENTRY_WIDTH-1:0] scaled_quotient(
        logic signed [255:0] cof, logic signed [255:0] det, ref bit sat);
        logic signed [255:0] num;
        logic [255:0]        an, ad, q, limit;
        bit                  neg;
        num   = cof <<< (2 * FRACTION_BITS_DEF);
        neg   = (num < 0) != (det < 0);
        an    = (num < 0) ? -num : num;
        ad    = (det < 0) ? -det : det;
        q     = (2 * an + ad) / (2 * ad);
        limit = neg ? (256'd1 << (ENTRY_WIDTH - 1)) : ((256'd1 << (ENTRY_WIDTH - 1)) - 1);
        if (q > limit) begin
            q   = limit;
            sat = 1'b1;
        end
        return neg ? -q[ENTRY_WIDTH-1:0] : q[ENTRY_WIDTH-1:0];
    endfunction

    function automatic out_item_t invert_matrix(in_item_t m);
        logic signed [255:0] a [9];
        logic signed [255:0] c [9];
        logic signed [255:0] det;
        logic [9*ENTRY_WIDTH-1:0] entries;
        out_item_t r;
        bit sat;
        sat = 1'b0;
        for (int k = 0; k < 9; k++)
            a[k] = signed'(m[(8 - k) * ENTRY_WIDTH +: ENTRY_WIDTH]);
        c[0] = a[4] * a[8] - a[5] * a[7];
        c[1] = a[2] * a[7] - a[1] * a[8];
        c[2] = a[1] * a[5] - a[2] * a[4];
        c[3] = a[5] * a[6] - a[3] * a[8];
        c[4] = a[0] * a[8] - a[2] * a[6];
        c[5] = a[2] * a[3] - a[0] * a[5];
        c[6] = a[3] * a[7] - a[4] * a[6];
        c[7] = a[1] * a[6] - a[0] * a[7];
        c[8] = a[0] * a[4] - a[1] * a[3];
        det  = a[0] * c[0] + a[1] * c[3] + a[2] * c[6];
        r = '0;
        if (det == 0) begin
            r.singular = 1'b1;
            return r;
        end
        for (int k = 0; k < 9; k++)
            entries[(8 - k) * ENTRY_WIDTH +: ENTRY_WIDTH] = scaled_quotient(c[k], det, sat);
        r = {entries, 1'b0, sat};
        return r;
    endfunction

    function automatic in_item_t diag_matrix(logic [ENTRY_WIDTH-1:0] d);
        in_item_t m;
        m = '0;
        m.a11 = d;
        m.a22 = d;
        m.a33 = d;
        return m;
    endfunction

    function automatic out_item_t diag_inverse(logic [ENTRY_WIDTH-1:0] d, bit sat);
        out_item_t r;
        r = '0;
        r.inv11 = d;
        r.inv22 = d;
        r.inv33 = d;
        r.saturated = sat;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Random matrices of several kinds, weighted toward invertible ones.
    // ------------------------------------------------------------------------
    function automatic logic [ENTRY_WIDTH-1:0] any_entry();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) return MAXP;
        if (pick == 1) return MAXN;
        if (pick == 2) return '0;
        return $urandom();
    endfunction

    function automatic in_item_t random_matrix();
        in_item_t    m;
        int unsigned kind;
        logic [ENTRY_WIDTH-1:0] v;
        kind = $urandom_range(0, 99);
        m = '0;
        for (int k = 0; k < 9; k++) begin
            if (kind < 40)                          // modest, diagonal boosted
                v = $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
            else if (kind < 60)                     // raw 32-bit words
                v = $urandom();
            else if (kind < 75)                     // extremes mixed in
                v = any_entry();
            else if (kind < 88)                     // tiny, likely saturating
                v = $urandom_range(0, 64) - 32;
            else
                v = $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
            m[(8 - k) * ENTRY_WIDTH +: ENTRY_WIDTH] = v;
        end
        if (kind < 40) begin
            m.a11 = m.a11 + 32'h0010_0000;
            m.a22 = m.a22 - 32'h0010_0000;
            m.a33 = m.a33 + 32'h0010_0000;
        end else if (kind >= 88) begin
            // make it singular: duplicate a row or zero a column
            case ($urandom_range(0, 2))
                0: {m.a31, m.a32, m.a33} = {m.a11, m.a12, m.a13};
                1: {m.a21, m.a22, m.a23} = {m.a31, m.a32, m.a33};
                default: {m.a12, m.a22, m.a32} = '0;
            endcase
        end
        return m;
    endfunction

    function automatic int pick_gap();
        int unsigned r;
        if (calm_phase) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Drive one matrix and hold it until the transfer completes.
    task automatic send_matrix(in_item_t m);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= m;
        do @(posedge aclk); while (!s_ready);
    endtask

    // ------------------------------------------------------------------------
    // Record the expected inverse on every input transfer.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            pending_inverses.push_back(override_on ? override_want : invert_matrix(s_data));
    end

    // Compare every output transfer with the oldest expectation.
    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (pending_inverses.size() == 0) begin
                $error("result with nothing expected");
                error_count++;
            end else begin
                want = pending_inverses.pop_front();
                for (int k = 0; k < 9; k++) begin
                    if (m_data[2 + (8 - k) * ENTRY_WIDTH +: ENTRY_WIDTH] !==
                        want[2 + (8 - k) * ENTRY_WIDTH +: ENTRY_WIDTH]) begin
                        $error("inv%0d%0d expected %h actual %h", k / 3 + 1, k % 3 + 1,
                               want[2 + (8 - k) * ENTRY_WIDTH +: ENTRY_WIDTH],
                               m_data[2 + (8 - k) * ENTRY_WIDTH +: ENTRY_WIDTH]);
                        error_count++;
                    end
                end
                if (m_data.singular !== want.singular) begin
                    $error("singular expected %b actual %b", want.singular, m_data.singular);
                    error_count++;
                end
                if (m_data.saturated !== want.saturated) begin
                    $error("saturated expected %b actual %b", want.saturated, m_data.saturated);
                    error_count++;
                end
            end
        end
    end

    // Receiver: random stalls, one long hold-off once results are flowing
    // so the pipeline backs up into the input side.
    initial begin
        int  hold_left;
        bit  hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge aclk);
            if (!hold_done && results_seen >= 200) begin
                hold_done = 1'b1;
                hold_left = RX_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (calm_phase) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(0, 99) < 70);
            end
        end
    end

    // Watchdog: end the run when neither side moves for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    typedef struct {
        in_item_t  mat;
        bit        fixed;     // expected result typed in below
        out_item_t want;
    } directed_row_t;

    initial begin
        directed_row_t rows[$];
        directed_row_t row;
        in_item_t      m;

        // identity and simple diagonals
        rows.push_back('{diag_matrix(ONE), 1'b1, diag_inverse(ONE, 1'b0)});
        rows.push_back('{diag_matrix(2 * ONE), 1'b1, diag_inverse(HALF, 1'b0)});
        rows.push_back('{diag_matrix(-ONE), 1'b1, diag_inverse(-ONE, 1'b0)});
        // singular: zero matrix, all-equal matrices
        rows.push_back('{'0, 1'b1, out_item_t'(2'b10)});
        rows.push_back('{{9{MAXP}}, 1'b1, out_item_t'(2'b10)});
        rows.push_back('{{9{MAXN}}, 1'b1, out_item_t'(2'b10)});
        rows.push_back('{{9{32'hffff_ffff}}, 1'b1, out_item_t'(2'b10)});
        // one-ulp diagonals overflow on both sides
        rows.push_back('{diag_matrix(32'd1), 1'b1, diag_inverse(MAXP, 1'b1)});
        rows.push_back('{diag_matrix(-32'sd1), 1'b1, diag_inverse(MAXN, 1'b1)});
        // the rest go through the model: extreme diagonals, mixed extremes, assorted matrices
        rows.push_back('{diag_matrix(MAXP), 1'b0, '0});
        rows.push_back('{diag_matrix(MAXN), 1'b0, '0});
        m = '0;
        {m.a12, m.a23, m.a31} = {ONE, ONE, ONE};          // permutation
        rows.push_back('{m, 1'b0, '0});
        m = '{MAXP, MAXN, 0, MAXN, MAXP, MAXN, 0, MAXN, MAXP};
        rows.push_back('{m, 1'b0, '0});
        m = '{MAXN, MAXP, MAXP, MAXP, MAXN, MAXP, MAXP, MAXP, MAXN};
        rows.push_back('{m, 1'b0, '0});
        m = '{ONE, 2 * ONE, 3 * ONE, 4 * ONE, 5 * ONE, 6 * ONE, 7 * ONE, 8 * ONE, 10 * ONE};
        rows.push_back('{m, 1'b0, '0});
        m = '{3 * ONE, 0, 0, 0, 3 * ONE, 0, 0, 0, 6 * ONE};  // thirds and sixths
        rows.push_back('{m, 1'b0, '0});
        m = '{ONE, ONE, 0, ONE, ONE + 32'd1, 0, 0, 0, ONE};   // nearly singular
        rows.push_back('{m, 1'b0, '0});
        m = '{32'h5555_5555, 32'haaaa_aaaa, 32'h0f0f_0f0f, 32'hf0f0_f0f0, 32'h3333_3333,
              32'hcccc_cccc, 32'h00ff_00ff, 32'hff00_ff00, 32'h1234_5678};
        rows.push_back('{m, 1'b0, '0});

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed table: typed rows replace the model's expectation; the
        // choice is driven alongside the matrix so it lands with the transfer.
        foreach (rows[i]) begin
            row = rows[i];
            override_on   <= row.fixed;
            override_want <= row.want;
            send_matrix(row.mat);
        end
        override_on <= 1'b0;

        // Random part; pause once until everything has drained, and run a
        // stretch with no idling on either side.
        for (int n = 0; n < NUM_RANDOM; n++) begin
            if (n == NUM_RANDOM / 2) begin
                s_valid <= 1'b0;
                @(posedge aclk);
                while (pending_inverses.size() > 0) @(posedge aclk);
                @(posedge aclk);
            end
            calm_phase = (n >= 900 && n < 1100);
            send_matrix(random_matrix());
        end
        s_valid <= 1'b0;

        @(posedge aclk);
        while (pending_inverses.size() > 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (pending_inverses.size() != 0) begin
            $error("%0d results never arrived", pending_inverses.size());
            error_count++;
        end
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
